[rtl/fpsac_pkg.sv]
// ----------------------------------------------------------------------------
// fpsac_pkg
// Shared types and constants for the frame parser with sum/addsum checks.
// ----------------------------------------------------------------------------
package fpsac_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hFF;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_HDR2   = 3'd1,
        PH_TYPE   = 3'd2,
        PH_LEN    = 3'd3,
        PH_DATA   = 3'd4,
        PH_SUM    = 3'd5,
        PH_ADDSUM = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_ACCEPT  = 2'd2,
        EV_REJECT  = 2'd3
    } t_event;

endpackage

[rtl/frame_parser_sum_add_checksum_top.sv]
// ----------------------------------------------------------------------------
// frame_parser_sum_add_checksum_top
// Byte-stream parser for AA FF type length payload sum addsum frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_rx_valid / o_rx_ready) takes one received byte per word.
//   Output channel (o_res_valid / i_res_ready) gives exactly one result word
//   per input word: an event code (none, payload byte, frame accepted, frame
//   rejected), the payload byte and its index, and the current frame type
//   and length.
//   The result for a byte is registered at the clock edge that accepts it.
//   Throughput: one byte per cycle unless the receiver stalls. The frame state (phase, type, length,
//   payload count, running sum and sum of sums) updates in the same cycle
//   the byte is taken; the result sits in a single output register.
//   Stall: while the receiver holds i_res_ready low with a result pending,
//   o_rx_ready drops; a new byte is taken in the cycle the pending result
//   drains, so no bubble is added.
//   Reset (i_rst_n low, synchronous): parser returns to hunting for the
//   first header byte, type/length/count/sums clear, no result pending.
//   A wrong second header byte returns to hunting; it is not retried as a
//   first header byte.
// ----------------------------------------------------------------------------
module frame_parser_sum_add_checksum_top
    import fpsac_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [1:0] o_event_res,
    output logic       o_frame_ok,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_payload_index,
    output logic [7:0] o_frame_kind,
    output logic [7:0] o_payload_length
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_kind, n_kind;
    logic [7:0] r_length, n_length;
    logic [7:0] r_byte_count, n_byte_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_sum2, n_sum2;

    logic       r_res_valid;
    t_event     r_event, n_event;
    logic       r_ok, n_ok;
    logic [7:0] r_pbyte, n_pbyte;
    logic [7:0] r_pidx, n_pidx;

    logic       rx_take;
    logic [7:0] acc_sum;
    logic [7:0] acc_sum2;
    logic [7:0] count_inc;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign rx_take    = i_rx_valid && o_rx_ready;

    assign acc_sum   = r_sum + i_rx_byte;
    assign acc_sum2  = r_sum2 + acc_sum;
    assign count_inc = r_byte_count + 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_length     = r_length;
        n_byte_count = r_byte_count;
        n_sum        = r_sum;
        n_sum2       = r_sum2;
        n_event      = EV_NONE;
        n_ok         = 1'b0;
        n_pbyte      = 8'd0;
        n_pidx       = 8'd0;
        case (r_phase)
            PH_HDR2: begin
                if (i_rx_byte == HDR_SECOND) begin
                    n_sum   = acc_sum;
                    n_sum2  = acc_sum2;
                    n_phase = PH_TYPE;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_TYPE: begin
                n_kind  = i_rx_byte;
                n_sum   = acc_sum;
                n_sum2  = acc_sum2;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_length     = i_rx_byte;
                n_sum        = acc_sum;
                n_sum2       = acc_sum2;
                n_byte_count = 8'd0;
                // zero length goes straight to the checksum
                n_phase      = (i_rx_byte != 8'd0) ? PH_DATA : PH_SUM;
            end
            PH_DATA: begin
                n_event      = EV_PAYLOAD;
                n_pbyte      = i_rx_byte;
                n_pidx       = r_byte_count;
                n_sum        = acc_sum;
                n_sum2       = acc_sum2;
                n_byte_count = count_inc;
                if (count_inc >= r_length) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                if (i_rx_byte == r_sum) begin
                    n_phase = PH_ADDSUM;
                end else begin
                    n_event = EV_REJECT;
                    n_phase = PH_HUNT;
                end
            end
            PH_ADDSUM: begin
                if (i_rx_byte == r_sum2) begin
                    n_event = EV_ACCEPT;
                    n_ok    = 1'b1;
                end else begin
                    n_event = EV_REJECT;
                end
                n_phase = PH_HUNT;
            end
            default: begin
                // hunting, and the unused phase code
                if (i_rx_byte == HDR_FIRST) begin
                    n_sum   = i_rx_byte;
                    n_sum2  = i_rx_byte;
                    n_phase = PH_HDR2;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_kind       <= 8'd0;
            r_length     <= 8'd0;
            r_byte_count <= 8'd0;
            r_sum        <= 8'd0;
            r_sum2       <= 8'd0;
            r_res_valid  <= 1'b0;
        end else begin
            if (rx_take) begin
                r_phase      <= n_phase;
                r_kind       <= n_kind;
                r_length     <= n_length;
                r_byte_count <= n_byte_count;
                r_sum        <= n_sum;
                r_sum2       <= n_sum2;
                r_res_valid  <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_event <= n_event;
            r_ok    <= n_ok;
            r_pbyte <= n_pbyte;
            r_pidx  <= n_pidx;
        end
    end

    // type and length shown are the values after this word's update
    logic [7:0] r_kind_out, r_length_out;
    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_kind_out   <= n_kind;
            r_length_out <= n_length;
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_event_res      = r_event;
    assign o_frame_ok       = r_ok;
    assign o_payload_byte   = r_pbyte;
    assign o_payload_index  = r_pidx;
    assign o_frame_kind     = r_kind_out;
    assign o_payload_length = r_length_out;

`ifndef NO_ASSERTIONS
    a_ok_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_ok |-> o_event_res == EV_ACCEPT)
        else $error("frame_ok without accept event");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_byte_count < r_length)
        else $error("payload count beyond length");

    a_data_gives_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_take && r_phase == PH_DATA |=> o_res_valid && o_event_res == EV_PAYLOAD)
        else $error("payload byte not reported");

    a_header_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_take && r_phase == PH_HUNT && i_rx_byte == HDR_FIRST
        |=> r_phase == PH_HDR2 && r_sum == HDR_FIRST)
        else $error("first header not taken");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives a byte stream into the AA FF frame parser and checks every result
// word against a cycle-free model of the parser, with random source gaps and
// random sink stalls. Covers good frames, empty payloads, header, sum and
// addsum faults, cut frames, line noise and one longest frame.
// ----------------------------------------------------------------------------
module tb_top;
    import fpsac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        t_event     ev;
        logic       ok;
        logic [7:0] pbyte;
        logic [7:0] pidx;
        logic [7:0] kind;
        logic [7:0] len;
    } t_parse_result;

    typedef enum {FAULT_NONE, FAULT_SUM, FAULT_ADDSUM, FAULT_HDR2, FAULT_CUT} t_frame_fault;
    typedef enum {SINK_OPEN, SINK_COIN, SINK_RUNS} t_sink_mode;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [1:0] event_res;
    logic       frame_ok;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_kind;
    logic [7:0] payload_length;

    // parser model state
    t_phase     mdl_phase;
    logic [7:0] mdl_kind;
    logic [7:0] mdl_len;
    logic [7:0] mdl_count;
    logic [7:0] mdl_sum;
    logic [7:0] mdl_sum2;

    t_parse_result expected_q[$];
    t_parse_result want;
    int         err_count = 0;
    int         items_sent = 0;
    int         burst_left = 0;
    int         cycle_count = 0;
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_timer = 0;
    int         run_left = 0;
    logic       run_high = 1'b0;

    frame_parser_sum_add_checksum_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_rx_valid       (rx_valid),
        .o_rx_ready       (rx_ready),
        .i_rx_byte        (rx_byte),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_event_res      (event_res),
        .o_frame_ok       (frame_ok),
        .o_payload_byte   (payload_byte),
        .o_payload_index  (payload_index),
        .o_frame_kind     (frame_kind),
        .o_payload_length (payload_length)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic void fold_into_sums(logic [7:0] b);
        mdl_sum  = mdl_sum + b;
        mdl_sum2 = mdl_sum2 + mdl_sum;
    endfunction

    function automatic t_parse_result predict_byte(logic [7:0] b);
        t_parse_result r;
        r = '0;
        case (mdl_phase)
            PH_HDR2: begin
                if (b == HDR_SECOND) begin
                    fold_into_sums(b);
                    mdl_phase = PH_TYPE;
                end else begin
                    mdl_phase = PH_HUNT;
                end
            end
            PH_TYPE: begin
                mdl_kind = b;
                fold_into_sums(b);
                mdl_phase = PH_LEN;
            end
            PH_LEN: begin
                mdl_len = b;
                fold_into_sums(b);
                mdl_count = '0;
                mdl_phase = (b != 8'd0) ? PH_DATA : PH_SUM;
            end
            PH_DATA: begin
                r.ev = EV_PAYLOAD;
                r.pbyte = b;
                r.pidx = mdl_count;
                fold_into_sums(b);
                mdl_count = mdl_count + 8'd1;
                if (mdl_count >= mdl_len)
                    mdl_phase = PH_SUM;
            end
            PH_SUM: begin
                if (b == mdl_sum) begin
                    mdl_phase = PH_ADDSUM;
                end else begin
                    r.ev = EV_REJECT;
                    mdl_phase = PH_HUNT;
                end
            end
            PH_ADDSUM: begin
                if (b == mdl_sum2) begin
                    r.ev = EV_ACCEPT;
                    r.ok = 1'b1;
                end else begin
                    r.ev = EV_REJECT;
                end
                mdl_phase = PH_HUNT;
            end
            default: begin
                if (b == HDR_FIRST) begin
                    mdl_sum = b;
                    mdl_sum2 = b;
                    mdl_phase = PH_HDR2;
                end else begin
                    mdl_phase = PH_HUNT;
                end
            end
        endcase
        r.kind = mdl_kind;
        r.len = mdl_len;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] exp_val);
        $display("mismatch @%0d: %s got %02h want %02h", cycle_count, field, got, exp_val);
        err_count++;
    endtask

    // source side: bursts of back-to-back words with random gaps between
    task automatic send_rx_word(logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        expected_q.insert(expected_q.size(), predict_byte(b));
        items_sent++;
    endtask

    // fill < 0 gives random payload, else every payload byte is fill
    task automatic send_frame(logic [7:0] kind, logic [7:0] len, t_frame_fault fault, int fill);
        logic [7:0] frame_q[$];
        logic [7:0] sum;
        logic [7:0] sum2;
        int         n_send;
        frame_q.insert(frame_q.size(), HDR_FIRST);
        frame_q.insert(frame_q.size(),
                       (fault == FAULT_HDR2) ? 8'($urandom_range(0, 254)) : HDR_SECOND);
        frame_q.insert(frame_q.size(), kind);
        frame_q.insert(frame_q.size(), len);
        for (int i = 0; i < len; i++)
            frame_q.insert(frame_q.size(), (fill < 0) ? 8'($urandom) : fill[7:0]);
        sum = '0;
        sum2 = '0;
        foreach (frame_q[i]) begin
            sum = sum + frame_q[i];
            sum2 = sum2 + sum;
        end
        if (fault == FAULT_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        if (fault == FAULT_ADDSUM)
            sum2 = sum2 ^ 8'($urandom_range(1, 255));
        frame_q.insert(frame_q.size(), sum);
        frame_q.insert(frame_q.size(), sum2);
        n_send = (fault == FAULT_CUT) ? $urandom_range(2, frame_q.size() - 1) : frame_q.size();
        for (int i = 0; i < n_send; i++)
            send_rx_word(frame_q[i]);
    endtask

    task automatic test_good_frame();
        send_frame(8'h00, 8'd1, FAULT_NONE, 8'hFF);
    endtask

    task automatic test_zero_length();
        send_frame(8'hFF, 8'd0, FAULT_NONE, -1);
    endtask

    // second AA must not restart the header; the FF after it is plain noise
    task automatic test_bad_second_header();
        send_rx_word(HDR_FIRST);
        send_rx_word(HDR_FIRST);
        send_rx_word(HDR_SECOND);
    endtask

    task automatic test_checksum_faults();
        send_frame(8'h5A, 8'd0, FAULT_SUM, -1);
        send_frame(8'hA5, 8'd1, FAULT_ADDSUM, 8'h00);
    endtask

    task automatic test_longest_frame();
        send_frame(8'($urandom), 8'd255, FAULT_NONE, -1);
    endtask

    task automatic test_random_stream();
        int pick;
        int n_noise;
        logic [7:0] len;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            len = ($urandom_range(0, 49) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
            if (pick <= 12) begin
                send_frame(8'($urandom), len, FAULT_NONE, -1);
            end else if (pick == 13) begin
                send_frame(8'($urandom), len, FAULT_SUM, -1);
            end else if (pick == 14) begin
                send_frame(8'($urandom), len, FAULT_ADDSUM, -1);
            end else if (pick == 15) begin
                send_frame(8'($urandom), len, FAULT_HDR2, -1);
            end else if (pick <= 17) begin
                send_frame(8'($urandom), len, FAULT_CUT, -1);
            end else begin
                n_noise = $urandom_range(1, 4);
                repeat (n_noise)
                    send_rx_word(($urandom_range(0, 3) == 0) ? HDR_FIRST : 8'($urandom));
            end
        end
    endtask

    // sink side: switches among always ready, coin flips and long stall runs
    always @(posedge clk) begin
        if (sink_timer == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            sink_timer = $urandom_range(20, 80);
        end
        sink_timer--;
        case (sink_mode)
            SINK_OPEN: res_ready <= 1'b1;
            SINK_COIN: res_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (run_left == 0) begin
                    run_high = !run_high;
                    run_left = run_high ? $urandom_range(1, 4) : $urandom_range(1, 8);
                end
                run_left--;
                res_ready <= run_high;
            end
        endcase
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && res_valid && res_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result word with nothing pending", {6'd0, event_res}, 8'd0);
            end else begin
                want = expected_q.pop_front();
                if (event_res !== want.ev)
                    report_mismatch("event_res", {6'd0, event_res}, {6'd0, want.ev});
                if (frame_ok !== want.ok)
                    report_mismatch("frame_ok", {7'd0, frame_ok}, {7'd0, want.ok});
                if (payload_byte !== want.pbyte)
                    report_mismatch("payload_byte", payload_byte, want.pbyte);
                if (payload_index !== want.pidx)
                    report_mismatch("payload_index", payload_index, want.pidx);
                if (frame_kind !== want.kind)
                    report_mismatch("frame_kind", frame_kind, want.kind);
                if (payload_length !== want.len)
                    report_mismatch("payload_length", payload_length, want.len);
            end
        end
    end

    initial begin
        rst_n <= 1'b0;
        rx_valid <= 1'b0;
        rx_byte <= 8'h00;
        mdl_phase = PH_HUNT;
        mdl_kind = '0;
        mdl_len = '0;
        mdl_count = '0;
        mdl_sum = '0;
        mdl_sum2 = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_good_frame();
        test_zero_length();
        test_bad_second_header();
        test_checksum_faults();
        test_longest_frame();
        test_random_stream();

        rx_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/fpsac_pkg.sv
rtl/frame_parser_sum_add_checksum_top.sv
tb/tb_top.sv
